FILE: rtl/eabe_pkg.sv
// eabe_pkg: types and constants for the ebpf alu and branch execute unit
// used by eabe_divider and ebpf_alu_branch_execute
package eabe_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        start_argument;
    logic [7:0]         opcode;
    logic [3:0]         dest_reg;
    logic [3:0]         source_reg;
    logic signed [15:0] jump_offset;
    logic [31:0]        immediate;
  } eabe_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] next_pc;
    logic [31:0]        return_value;
  } eabe_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } eabe_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [63:0] remainder;
  } eabe_div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN
  } eabe_state_e;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_EXEC  = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [1:0] ST_CONT = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [15:0] PC_HALT = 16'hFFFF;

  localparam logic [7:0] OP_EXIT = 8'h95;
  localparam logic [7:0] OP_JA   = 8'h05;

  localparam logic [2:0] CLS_ALU   = 3'h4;
  localparam logic [2:0] CLS_JMP   = 3'h5;
  localparam logic [2:0] CLS_ALU64 = 3'h7;

  localparam logic [3:0] ALU_ADD  = 4'h0;
  localparam logic [3:0] ALU_SUB  = 4'h1;
  localparam logic [3:0] ALU_MUL  = 4'h2;
  localparam logic [3:0] ALU_DIV  = 4'h3;
  localparam logic [3:0] ALU_OR   = 4'h4;
  localparam logic [3:0] ALU_AND  = 4'h5;
  localparam logic [3:0] ALU_LSH  = 4'h6;
  localparam logic [3:0] ALU_RSH  = 4'h7;
  localparam logic [3:0] ALU_NEG  = 4'h8;
  localparam logic [3:0] ALU_MOD  = 4'h9;
  localparam logic [3:0] ALU_XOR  = 4'ha;
  localparam logic [3:0] ALU_MOV  = 4'hb;
  localparam logic [3:0] ALU_ARSH = 4'hc;

  localparam logic [3:0] JMP_JEQ  = 4'h1;
  localparam logic [3:0] JMP_JGT  = 4'h2;
  localparam logic [3:0] JMP_JGE  = 4'h3;
  localparam logic [3:0] JMP_JSET = 4'h4;
  localparam logic [3:0] JMP_JNE  = 4'h5;
  localparam logic [3:0] JMP_JSGT = 4'h6;
  localparam logic [3:0] JMP_JSGE = 4'h7;
  localparam logic [3:0] JMP_JLT  = 4'ha;
  localparam logic [3:0] JMP_JLE  = 4'hb;
  localparam logic [3:0] JMP_JSLT = 4'hc;
  localparam logic [3:0] JMP_JSLE = 4'hd;

endpackage

FILE: rtl/eabe_ram.sv
// eabe_ram: generic ram, one write port and two registered read ports
// no dependencies
module eabe_ram #(
  parameter int Width = 64,
  parameter int Depth = 10
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_a_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_b_i,
  output logic [Width-1:0]                         rdata_a_o,
  output logic [Width-1:0]                         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/eabe_divider.sv
// eabe_divider: 64-bit unsigned restoring divider, one quotient bit a cycle
// depends on eabe_pkg
module eabe_divider
  import eabe_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  eabe_div_req_t req_i,
  output eabe_div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] dsr_q, dsr_d;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[63]};
    diff   = rem_sh - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_d = diff[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: rtl/ebpf_alu_branch_execute.sv
// ebpf_alu_branch_execute: top level of the ebpf alu and branch execute unit
// depends on eabe_pkg, eabe_ram and eabe_divider
//
// channel | direction | handshake             | word
// in      | input     | in_valid_i/in_ready_o | eabe_in_t in_data_i
// out     | output    | out_valid_o/out_ready_i | eabe_out_t out_data_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | program_length cfg_data_i
//
// one word at a time: an accepted word passes S_EXEC, then S_MUL for a multiply
// (four steps of one 32x32 multiplier) or S_DIV for divide and modulo by nonzero
// (64-step divider), then S_FIN; the register file read is registered
// reset: pc halted, register file reads zero through per-entry valid bits
// a new word is taken while the previous result still waits on out
module ebpf_alu_branch_execute
  import eabe_pkg::*;
#(
  parameter int NUM_REGS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  eabe_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output eabe_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [12:0] cfg_data_i
);

  localparam int RegAw = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [3:0] NumRegsW = 4'(NUM_REGS);

  eabe_state_e state_q, state_d;
  eabe_in_t    item_q;
  logic [12:0] len_q;
  logic [15:0] pc_q, pc_d;
  logic [NUM_REGS-1:0] valid_q;
  logic        rva_q, rvb_q;
  logic        out_valid_q;
  eabe_out_t   out_data_q;
  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_ret_q, res_ret_d;
  logic [1:0]  mul_step_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;

  logic             in_acc, out_load;
  logic [RegAw-1:0] rd_a, rd_b;
  logic [63:0]      ram_a, ram_b, a_val, b_reg;
  logic             ram_we;
  logic [RegAw-1:0] ram_waddr;
  logic [63:0]      ram_wdata;

  logic [2:0]  cls;
  logic [3:0]  code;
  logic        use_src, wide;
  logic [63:0] mask, am, bm, jb;
  logic [5:0]  sh;
  logic [31:0] sr32;
  logic [63:0] alu_r;
  logic        alu_ok, taken, jmp_ok;
  logic [RegAw-1:0] dst_a;
  logic [63:0] mul_x, mul_y;
  logic [31:0] mul_hi;

  logic        ex_go_mul, ex_go_div;
  logic [63:0] div_r;

  eabe_div_req_t div_req;
  eabe_div_rsp_t div_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    rd_a = (in_data_i.dest_reg < NumRegsW) ? in_data_i.dest_reg[RegAw-1:0] : '0;
    if (in_data_i.mode == MODE_STOP) begin
      rd_a = '0;
    end
    rd_b = (in_data_i.source_reg < NumRegsW) ? in_data_i.source_reg[RegAw-1:0] : '0;
  end

  eabe_ram #(
    .Width(64),
    .Depth(NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (in_acc),
    .raddr_a_i (rd_a),
    .raddr_b_i (rd_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  eabe_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign a_val = rva_q ? ram_a : '0;
  assign b_reg = rvb_q ? ram_b : '0;

  // operand, alu, jump and multiply decode
  always_comb begin
    cls     = item_q.opcode[2:0];
    code    = item_q.opcode[7:4];
    use_src = item_q.opcode[3];
    wide    = (cls == CLS_ALU64);
    mask    = wide ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    jb      = use_src ? b_reg : {32'd0, item_q.immediate};
    am      = a_val & mask;
    bm      = jb & mask;
    sh      = wide ? bm[5:0] : {1'b0, bm[4:0]};
    sr32    = 32'($signed(am[31:0]) >>> bm[4:0]);
    dst_a   = item_q.dest_reg[RegAw-1:0];
    alu_ok  = 1'b1;
    alu_r   = '0;
    unique case (code)
      ALU_ADD:  alu_r = am + bm;
      ALU_SUB:  alu_r = am - bm;
      ALU_OR:   alu_r = am | bm;
      ALU_AND:  alu_r = am & bm;
      ALU_LSH:  alu_r = am << sh;
      ALU_RSH:  alu_r = am >> sh;
      ALU_NEG:  alu_r = 64'd0 - am;
      ALU_XOR:  alu_r = am ^ bm;
      ALU_MOV:  alu_r = bm;
      ALU_ARSH: alu_r = wide ? 64'($signed(am) >>> sh) : {32'd0, sr32};
      ALU_MUL, ALU_DIV, ALU_MOD: alu_r = '0;
      default:  alu_ok = 1'b0;
    endcase
    alu_r  = alu_r & mask;
    jmp_ok = 1'b1;
    taken  = 1'b0;
    unique case (code)
      JMP_JEQ:  taken = (a_val == jb);
      JMP_JGT:  taken = (a_val > jb);
      JMP_JGE:  taken = (a_val >= jb);
      JMP_JSET: taken = ((a_val & jb) != '0);
      JMP_JNE:  taken = (a_val != jb);
      JMP_JSGT: taken = ($signed(a_val) > $signed(jb));
      JMP_JSGE: taken = ($signed(a_val) >= $signed(jb));
      JMP_JLT:  taken = (a_val < jb);
      JMP_JLE:  taken = (a_val <= jb);
      JMP_JSLT: taken = ($signed(a_val) < $signed(jb));
      JMP_JSLE: taken = ($signed(a_val) <= $signed(jb));
      default:  jmp_ok = 1'b0;
    endcase
    unique case (mul_step_q)
      2'd0: begin
        mul_x = {32'd0, am[31:0]};
        mul_y = {32'd0, bm[31:0]};
      end
      2'd1: begin
        mul_x = {32'd0, am[31:0]};
        mul_y = {32'd0, bm[63:32]};
      end
      default: begin
        mul_x = {32'd0, am[63:32]};
        mul_y = {32'd0, bm[31:0]};
      end
    endcase
    mul_hi = acc_q[63:32] + prod_q[31:0];
    div_r  = ((code == ALU_DIV) ? div_rsp.quotient : div_rsp.remainder) & mask;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: begin
        if (ex_go_mul) begin
          state_d = S_MUL;
        end else if (ex_go_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MUL:  if (mul_step_q == 2'd3) state_d = S_FIN;
      S_DIV:  if (div_rsp.done) state_d = S_FIN;
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    pc_d          = pc_q;
    res_status_d  = res_status_q;
    res_ret_d     = res_ret_q;
    ram_we        = 1'b0;
    ram_waddr     = dst_a;
    ram_wdata     = alu_r;
    ex_go_mul     = 1'b0;
    ex_go_div     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = am;
    div_req.divisor  = bm;
    unique case (state_q)
      S_EXEC: begin
        res_status_d = ST_ERR;
        res_ret_d    = '0;
        unique case (item_q.mode)
          MODE_START: begin
            if (pc_q == PC_HALT) begin
              pc_d         = '0;
              ram_we       = 1'b1;
              ram_waddr    = RegAw'(1);
              ram_wdata    = item_q.start_argument;
              res_status_d = ST_CONT;
            end
          end
          MODE_STOP: begin
            res_ret_d    = a_val[31:0];
            pc_d         = PC_HALT;
            res_status_d = ST_DONE;
          end
          MODE_EXEC: begin
            priority if (pc_q[15]) begin
              res_status_d = ST_ERR;
            end else if (pc_q >= {3'd0, len_q}) begin
              res_status_d = (pc_q == {3'd0, len_q}) ? ST_DONE : ST_ERR;
            end else if (item_q.opcode == OP_EXIT) begin
              res_status_d = ST_DONE;
            end else if (item_q.opcode == OP_JA) begin
              pc_d         = pc_q + 16'(item_q.jump_offset) + 16'd1;
              res_status_d = ST_CONT;
            end else if (cls != CLS_ALU && cls != CLS_JMP && cls != CLS_ALU64) begin
              res_status_d = ST_ERR;
            end else if (cls != CLS_JMP && code == ALU_NEG && use_src) begin
              res_status_d = ST_ERR;
            end else if (item_q.dest_reg >= NumRegsW ||
                         (use_src && item_q.source_reg >= NumRegsW)) begin
              res_status_d = ST_ERR;
            end else if (cls == CLS_JMP) begin
              if (jmp_ok) begin
                pc_d = pc_q + (taken ? 16'(item_q.jump_offset) : 16'd0) + 16'd1;
                res_status_d = ST_CONT;
              end
            end else if (alu_ok) begin
              res_status_d = ST_CONT;
              if (code == ALU_MUL) begin
                ex_go_mul = 1'b1;
              end else if ((code == ALU_DIV || code == ALU_MOD) && bm != '0) begin
                ex_go_div     = 1'b1;
                div_req.start = 1'b1;
              end else begin
                ram_we = 1'b1;
                if (code == ALU_DIV) begin
                  ram_wdata = '0;
                end else if (code == ALU_MOD) begin
                  ram_wdata = am;
                end
                pc_d = pc_q + 16'd1;
              end
            end
          end
          default: res_status_d = ST_ERR;
        endcase
      end
      S_MUL: begin
        if (mul_step_q == 2'd3) begin
          ram_we    = 1'b1;
          ram_wdata = {mul_hi, acc_q[31:0]} & mask;
          pc_d      = pc_q + 16'd1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = div_r;
          pc_d      = pc_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= PC_HALT;
      len_q        <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      mul_step_q   <= '0;
      res_status_q <= ST_CONT;
      res_ret_q    <= '0;
    end else begin
      state_q      <= state_d;
      pc_q         <= pc_d;
      res_status_q <= res_status_d;
      res_ret_q    <= res_ret_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_MUL) begin
        mul_step_q <= mul_step_q + 2'd1;
      end else begin
        mul_step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
      rva_q  <= valid_q[rd_a];
      rvb_q  <= valid_q[rd_b];
    end
    if (out_load) begin
      out_data_q.status       <= res_status_q;
      out_data_q.next_pc      <= pc_q;
      out_data_q.return_value <= res_ret_q;
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_x[31:0] * mul_y[31:0];
      unique case (mul_step_q)
        2'd1:    acc_q <= prod_q;
        2'd2:    acc_q <= {mul_hi, acc_q[31:0]};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EXEC)
    else $error("accepted word not executed");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider result outside divide wait");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC || state_q == S_MUL || state_q == S_DIV))
    else $error("register write outside execution");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status code");

endmodule
